FILE: rtl/core/multi_timer_countdown_bank_core_assert.svh
// Assertion macros shared by the countdown timer bank checkers.
`ifndef MULTI_TIMER_COUNTDOWN_BANK_CORE_ASSERT_SVH
`define MULTI_TIMER_COUNTDOWN_BANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MTCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, disabled while reset is low.
`define MTCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

FILE: rtl/core/mtcb_pkg.sv
// Shared types and constants for the countdown timer bank.
`default_nettype none
package mtcb_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 4;
  localparam int ELAPSED_W  = 32;
  localparam int PERIOD_W   = 32;
  localparam int DEADLINE_W = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESTART_NEW = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd5;

  // Result types and status codes.
  localparam logic RES_EXPIRY  = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_IGNORED  = 1'b1;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_WALK
  } ctrl_state_t;

  // Slot command broadcast to every cell.
  typedef struct packed {
    logic              wr;
    logic [KIND_W-1:0] kind;
    logic              rep;
    logic              del;
    logic              inact;
  } slot_cmd_t;

  // Per-cell status seen by the controller.
  typedef struct packed {
    logic in_use;
    logic expire;
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/mtcb_cell.sv
// One timer slot: holds its period, remaining time and flags, and passes the tick token on.
`default_nettype none
module mtcb_cell #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          sel_i,
  input  wire mtcb_pkg::slot_cmd_t           cmd_i,
  input  wire logic [TIME_BITS-1:0]          period_i,
  input  wire logic [mtcb_pkg::ELAPSED_W-1:0] elapsed_i,
  input  wire logic                          step_i,
  input  wire logic                          tok_i,
  input  wire logic [TIME_BITS-1:0]          best_i,
  output logic                               tok_o,
  output logic [TIME_BITS-1:0]               best_o,
  output mtcb_pkg::cell_stat_t               stat_o
);
  import mtcb_pkg::*;

  localparam int CMPW = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;

  logic [TIME_BITS-1:0] period_r, period_nxt;
  logic [TIME_BITS-1:0] remain_r, remain_nxt;
  logic                 act_r, act_nxt;
  logic                 use_r, use_nxt;
  logic                 rep_r, rep_nxt;
  logic                 del_r, del_nxt;
  logic                 tok_r;
  logic [TIME_BITS-1:0] best_r, best_nxt;

  logic                 live;
  logic                 el_zero;
  logic                 hit;
  logic                 expire;
  logic [TIME_BITS-1:0] left;

  // Countdown arithmetic for this slot when the token arrives.
  always_comb begin
    live    = use_r && act_r;
    el_zero = (elapsed_i == '0);
    hit     = (CMPW'(elapsed_i) + CMPW'(1)) >= CMPW'(remain_r);
    expire  = tok_i && live && !el_zero && hit;
    if (el_zero) begin
      left = remain_r;
    end else if (hit) begin
      left = (del_r && !rep_r) ? '0 : period_r;
    end else begin
      left = remain_r - TIME_BITS'(elapsed_i);
    end
    if (live && (left != '0) && ((best_i == '0) || (left < best_i))) begin
      best_nxt = left;
    end else begin
      best_nxt = best_i;
    end
  end

  // Next slot state from a command or from the tick walk.
  always_comb begin
    period_nxt = period_r;
    remain_nxt = remain_r;
    act_nxt    = act_r;
    use_nxt    = use_r;
    rep_nxt    = rep_r;
    del_nxt    = del_r;
    if (cmd_i.wr && sel_i) begin
      unique case (cmd_i.kind)
        KIND_CREATE: begin
          period_nxt = period_i;
          remain_nxt = period_i;
          rep_nxt    = cmd_i.rep;
          del_nxt    = cmd_i.del;
          act_nxt    = !cmd_i.inact;
          use_nxt    = 1'b1;
        end
        KIND_STOP: begin
          act_nxt = 1'b0;
        end
        KIND_RESTART: begin
          remain_nxt = period_r;
          act_nxt    = 1'b1;
        end
        KIND_RESTART_NEW: begin
          period_nxt = period_i;
          remain_nxt = period_i;
          act_nxt    = 1'b1;
        end
        KIND_REMOVE: begin
          use_nxt = 1'b0;
          act_nxt = 1'b0;
          rep_nxt = 1'b0;
          del_nxt = 1'b0;
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end else if (step_i && tok_i && live && !el_zero) begin
      remain_nxt = left;
      if (hit && !rep_r) begin
        act_nxt = 1'b0;
        if (del_r) begin
          use_nxt = 1'b0;
        end
      end
    end
  end

  // Control flags and token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      use_r <= 1'b0;
      rep_r <= 1'b0;
      del_r <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      use_r <= use_nxt;
      rep_r <= rep_nxt;
      del_r <= del_nxt;
      if (step_i) begin
        tok_r <= tok_i;
      end
    end
  end

  // Times and running minimum.
  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    remain_r <= remain_nxt;
    if (step_i && tok_i) begin
      best_r <= best_nxt;
    end
  end

  assign tok_o         = tok_r;
  assign best_o        = best_r;
  assign stat_o.in_use = use_r;
  assign stat_o.expire = expire;

endmodule
`default_nettype wire

FILE: rtl/core/multi_timer_countdown_bank_core.sv
// Top level of the countdown timer bank: request decode, tick walk control and result register.
//
//   Channel | Direction | Signals                      | Payload
//   in      | sink      | in_tvalid/tready/tdata/tuser | kind, slot, times, mode flags
//   out     | source    | out_tvalid/tready/tdata/tuser/tlast | expiry, summary or ack
//
// A create, stop, restart or remove request gives one acknowledge.
// A tick moves the token through the row of slot cells, one cell per cycle while the result
// register is free, and the summary leaves once the token falls off the end.
// Each expiry result and the summary wait while the result register is held by out_tready.
// Synchronous active-low reset clears all slot flags; the times read only after a create.
`default_nettype none
module multi_timer_countdown_bank_core #(
  parameter int TIMER_SLOTS = mtcb_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = mtcb_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // slot[3:0], elapsed_ms[35:4], period_ms[67:36], repeat_mode[68],
  // delete_mode[69], start_inactive[70], zero[71]
  input  wire logic [mtcb_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[2:0]
  input  wire logic [mtcb_pkg::KIND_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // expired_slot[3:0], next_deadline_ms[35:4], status[36], zero[39:37]
  output logic [mtcb_pkg::OUT_DATA_W-1:0]      out_tdata,
  // result_type[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import mtcb_pkg::*;

  localparam int CW = $clog2(TIMER_SLOTS);

  ctrl_state_t state_r, state_nxt;

  logic                  launch_r, launch_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [SLOT_W-1:0]     in_slot;
  logic [KIND_W-1:0]     in_kind;
  logic [TIME_BITS-1:0]  in_period;
  logic [CW-1:0]         slot_idx;
  logic                  slot_ok;
  logic                  use_sel;
  logic                  known_cmd;
  logic                  ack_status;
  logic                  accept;
  logic                  out_free;
  logic                  exp_any;
  logic                  tok_last;
  logic                  step;
  logic                  load_ack;
  logic                  load_exp;
  logic                  load_sum;
  slot_cmd_t             cmd;

  logic                  tok_chain  [TIMER_SLOTS+1];
  logic [TIME_BITS-1:0]  best_chain [TIMER_SLOTS+1];
  cell_stat_t            stat_vec   [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] use_vec;
  logic [TIMER_SLOTS-1:0] exp_vec;
  logic [TIMER_SLOTS-1:0] sel_vec;

  // Request field decode.
  always_comb begin
    in_kind    = in_tuser;
    in_slot    = in_tdata[3:0];
    in_period  = TIME_BITS'(in_tdata[67:36]);
    slot_idx   = CW'(in_slot);
    slot_ok    = (32'(in_slot) < 32'(TIMER_SLOTS));
    use_sel    = slot_ok && use_vec[slot_idx];
    known_cmd  = (in_kind != KIND_TICK) && (in_kind <= KIND_REMOVE);
    ack_status = known_cmd && (!slot_ok || ((in_kind != KIND_CREATE) && !use_sel));
    out_free   = !out_valid_r || out_tready;
    accept     = in_tvalid && in_tready;
    exp_any    = |exp_vec;
    tok_last   = tok_chain[TIMER_SLOTS];
  end

  // Command broadcast to the cells.
  always_comb begin
    cmd.wr    = accept && known_cmd && !ack_status;
    cmd.kind  = in_kind;
    cmd.rep   = in_tdata[68];
    cmd.del   = in_tdata[69];
    cmd.inact = in_tdata[70];
  end

  // Next-state logic of the controller.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTRL_IDLE: begin
        if (accept && (in_kind == KIND_TICK)) begin
          state_nxt = CTRL_WALK;
        end
      end
      CTRL_WALK: begin
        if (tok_last && out_free) begin
          state_nxt = CTRL_IDLE;
        end
      end
      default: begin
        state_nxt = CTRL_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_tready = 1'b0;
    step      = 1'b0;
    load_ack  = 1'b0;
    load_exp  = 1'b0;
    load_sum  = 1'b0;
    unique case (state_r)
      CTRL_IDLE: begin
        in_tready = out_free;
        load_ack  = accept && (in_kind != KIND_TICK);
      end
      CTRL_WALK: begin
        step     = (exp_any || tok_last) ? out_free : 1'b1;
        load_exp = exp_any && out_free;
        load_sum = tok_last && out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Walk bookkeeping: launch token, slot counter and latched elapsed time.
  always_comb begin
    launch_nxt  = launch_r;
    cnt_nxt     = cnt_r;
    elapsed_nxt = elapsed_r;
    if (accept && (in_kind == KIND_TICK)) begin
      launch_nxt  = 1'b1;
      cnt_nxt     = '0;
      elapsed_nxt = in_tdata[35:4];
    end else if (step) begin
      launch_nxt = 1'b0;
      cnt_nxt    = CW'(cnt_r + 1'b1);
    end
  end

  // Result register contents.
  always_comb begin
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    priority if (load_ack) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, ack_status, DEADLINE_W'(0), SLOT_W'(0)};
      out_user_nxt  = RES_SUMMARY;
      out_last_nxt  = 1'b1;
    end else if (load_exp) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, ST_DONE, DEADLINE_W'(0), SLOT_W'(cnt_r)};
      out_user_nxt  = RES_EXPIRY;
      out_last_nxt  = 1'b0;
    end else if (load_sum) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, ST_DONE, DEADLINE_W'(best_chain[TIMER_SLOTS]), SLOT_W'(0)};
      out_user_nxt  = RES_SUMMARY;
      out_last_nxt  = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTRL_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    elapsed_r  <= elapsed_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // Row of slot cells; the tick token and running minimum move one cell per step.
  assign tok_chain[0]  = launch_r;
  assign best_chain[0] = '0;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    assign sel_vec[i] = (slot_idx == CW'(i));
    assign use_vec[i] = stat_vec[i].in_use;
    assign exp_vec[i] = stat_vec[i].expire;

    mtcb_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .sel_i     (sel_vec[i]),
      .cmd_i     (cmd),
      .period_i  (in_period),
      .elapsed_i (elapsed_r),
      .step_i    (step),
      .tok_i     (tok_chain[i]),
      .best_i    (best_chain[i]),
      .tok_o     (tok_chain[i+1]),
      .best_o    (best_chain[i+1]),
      .stat_o    (stat_vec[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/mtcb_checker.sv
// Port-level checks for the countdown timer bank, bound to the top level.
`default_nettype none
`include "multi_timer_countdown_bank_core_assert.svh"
module mtcb_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [mtcb_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic [mtcb_pkg::KIND_W-1:0]     in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [mtcb_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tuser,
  input wire logic                            out_tlast
);
  import mtcb_pkg::*;

  logic in_req;
  logic out_stall;
  logic exp_seen;
  logic ack_seen;

  assign in_req    = in_tvalid && in_tready && (in_tdata[71] == 1'b0 || in_tuser != '1);
  assign out_stall = out_tvalid && !out_tready;
  assign exp_seen  = out_tvalid && (out_tuser == RES_EXPIRY);
  assign ack_seen  = out_tvalid && (out_tuser == RES_SUMMARY) && (out_tdata[36] == ST_IGNORED);

  // A stalled result keeps its payload.
  `MTCB_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A new request is never taken while the result register is blocked.
  `MTCB_ASSERT_IMP(a_no_accept_on_stall, clk, rst_n, in_req, !out_stall)

  // Expiry events are never the final result and carry no deadline or status.
  `MTCB_ASSERT_IMP(a_expiry_shape, clk, rst_n, exp_seen, !out_tlast && (out_tdata[36:4] == '0))

  // An ignored request gives one closing acknowledge with no deadline.
  `MTCB_ASSERT_IMP(a_ignored_shape, clk, rst_n, ack_seen, out_tlast && (out_tdata[35:0] == '0))

endmodule

bind multi_timer_countdown_bank_core mtcb_checker u_mtcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
